// File: rtl/nii_pkg.sv
`default_nettype none

package nii_pkg;

	localparam int PIX_W       = 8;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;
	localparam int SIDE_CFG_W  = 13;
	localparam int SHIFT_CFG_W = 2;
	localparam int MEAN_W      = 16;
	localparam int INV_W       = 24;
	localparam int AVG_W       = 16;
	localparam int DIFF_W      = AVG_W + 1;
	localparam int PROD_W      = DIFF_W + INV_W + 1;
	localparam int ROUND_SH    = 16;
	localparam int NORM_W      = 16;
	localparam int SUM_W       = 40;
	localparam int POS_W       = 10;

	localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(32768);
	localparam logic [NORM_W-1:0]        NORM_MAX   = 16'h7FFF;
	localparam logic [NORM_W-1:0]        NORM_MIN   = 16'h8000;

	localparam logic [SIDE_CFG_W-1:0]  RST_IN_WIDTH    = 13'd640;
	localparam logic [SIDE_CFG_W-1:0]  RST_IN_HEIGHT   = 13'd480;
	localparam logic [SHIFT_CFG_W-1:0] RST_SCALE_SHIFT = 2'd0;
	localparam logic [MEAN_W-1:0]      RST_MEAN        = 16'd0;
	localparam logic [INV_W-1:0]       RST_INV_STD     = 24'd65536;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IN_WIDTH    = 3'd0,
		REG_IN_HEIGHT   = 3'd1,
		REG_SCALE_SHIFT = 3'd2,
		REG_MEAN        = 3'd3,
		REG_INV_STD     = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic vld;
		logic inblk;
		logic first;
		logic last;
		logic lof;
	} blk_ctl_t;

endpackage

`default_nettype wire

// File: rtl/normalized_integral_image.sv
// Normalised integral image over a downscaled 8-bit pixel stream.
// Input channel: in_valid / in_stall with pixel and start_of_frame, one word per
// pixel in raster order. Output channel: out_valid / out_stall with area_sum
// (signed Q.8), out_row, out_col and last_of_frame; one word per completed block.
// Config: cfg_we / cfg_index / cfg_data; the user must write it only while the
// block is idle, which the block does not enforce. Throughput: one pixel per
// cycle while in_stall is low. Both block-sum and row-integral stores do one
// read and one write per cycle, with a one-entry bypass on each. Words pass
// stages s1 to s6 and the output register. The output register holds its word
// while out_stall is high; a stalled output with a word present freezes the
// whole pipeline and raises in_stall, otherwise input keeps flowing. A word at
// the output register does not stop acceptance when out_stall is low.
// Reset clears pipeline valids, pixel counters and the row sum and loads the
// default config. Block-sum and row-integral stores need no clearing: each entry
// is written before it is read within a frame.
`default_nettype none

module normalized_integral_image #(
	parameter int MAX_OUT_SIDE = 1024,
	parameter int MAX_IN_SIDE = 4096,
	parameter int MAX_SCALE_SHIFT = 3
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [nii_pkg::PIX_W-1:0]         pixel,
	input  logic                              start_of_frame,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [nii_pkg::SUM_W-1:0]  area_sum,
	output logic [nii_pkg::POS_W-1:0]         out_row,
	output logic [nii_pkg::POS_W-1:0]         out_col,
	output logic                              last_of_frame,
	input  logic                              cfg_we,
	input  logic [nii_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [nii_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import nii_pkg::*;

	localparam int OW = $clog2(MAX_OUT_SIDE);
	localparam int AW = PIX_W + 2 * MAX_SCALE_SHIFT;
	localparam int KW = $clog2(MAX_SCALE_SHIFT + 2);

	logic [SIDE_CFG_W-1:0]  in_width_q, in_height_q;
	logic [SHIFT_CFG_W-1:0] scale_shift_q;
	logic [MEAN_W-1:0]      mean_q;
	logic [INV_W-1:0]       inv_std_q;

	logic               en;
	logic [KW-1:0]      k;
	logic [PIX_W-1:0]   pixel_s1;
	logic [OW-1:0]      bc_s1, br_s1, bc_s3, br_s3, bc_s5, br_s5;
	blk_ctl_t           ctl_s1, ctl_s3, ctl_s5;
	logic [AW-1:0]      acc_s3;
	logic signed [NORM_W-1:0] v_s5;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_width_q    <= RST_IN_WIDTH;
			in_height_q   <= RST_IN_HEIGHT;
			scale_shift_q <= RST_SCALE_SHIFT;
			mean_q        <= RST_MEAN;
			inv_std_q     <= RST_INV_STD;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IN_WIDTH:    in_width_q    <= cfg_data[SIDE_CFG_W-1:0];
				REG_IN_HEIGHT:   in_height_q   <= cfg_data[SIDE_CFG_W-1:0];
				REG_SCALE_SHIFT: scale_shift_q <= cfg_data[SHIFT_CFG_W-1:0];
				REG_MEAN:        mean_q        <= cfg_data[MEAN_W-1:0];
				REG_INV_STD:     inv_std_q     <= cfg_data[INV_W-1:0];
				default: begin
				end
			endcase
		end
	end

	nii_position #(
		.MAX_OUT_SIDE(MAX_OUT_SIDE),
		.MAX_IN_SIDE(MAX_IN_SIDE),
		.MAX_SCALE_SHIFT(MAX_SCALE_SHIFT)
	) u_position (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(in_valid),
		.pixel(pixel),
		.start_of_frame(start_of_frame),
		.in_width(in_width_q),
		.in_height(in_height_q),
		.scale_shift(scale_shift_q),
		.k(k),
		.pixel_s1(pixel_s1),
		.bc_s1(bc_s1),
		.br_s1(br_s1),
		.ctl_s1(ctl_s1)
	);

	nii_accum #(
		.MAX_OUT_SIDE(MAX_OUT_SIDE),
		.MAX_SCALE_SHIFT(MAX_SCALE_SHIFT)
	) u_accum (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.pixel_s1(pixel_s1),
		.bc_s1(bc_s1),
		.br_s1(br_s1),
		.ctl_s1(ctl_s1),
		.acc_s3(acc_s3),
		.bc_s3(bc_s3),
		.br_s3(br_s3),
		.ctl_s3(ctl_s3)
	);

	nii_normalize #(
		.MAX_OUT_SIDE(MAX_OUT_SIDE),
		.MAX_SCALE_SHIFT(MAX_SCALE_SHIFT)
	) u_normalize (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.k(k),
		.mean_q8(mean_q),
		.inv_std_q16(inv_std_q),
		.acc_s3(acc_s3),
		.bc_s3(bc_s3),
		.br_s3(br_s3),
		.ctl_s3(ctl_s3),
		.v_s5(v_s5),
		.bc_s5(bc_s5),
		.br_s5(br_s5),
		.ctl_s5(ctl_s5)
	);

	nii_integrate #(
		.MAX_OUT_SIDE(MAX_OUT_SIDE)
	) u_integrate (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.v_s5(v_s5),
		.bc_s5(bc_s5),
		.br_s5(br_s5),
		.ctl_s5(ctl_s5),
		.out_valid(out_valid),
		.area_sum(area_sum),
		.out_row(out_row),
		.out_col(out_col),
		.last_of_frame(last_of_frame)
	);

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input held off with no word in the output register");

	a_frame_restarts_at_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last_of_frame)
		|=> (!out_valid || (out_row == '0 && out_col == '0)))
		else $error("word after frame end is not at row 0, column 0");

	a_column_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last_of_frame)
		|=> (!out_valid || out_col == '0 || out_col == POS_W'($past(out_col) + 10'd1)))
		else $error("downscaled column skipped within a row");

endmodule

`default_nettype wire

// File: rtl/nii_position.sv
`default_nettype none

module nii_position #(
	parameter int MAX_OUT_SIDE = 1024,
	parameter int MAX_IN_SIDE = 4096,
	parameter int MAX_SCALE_SHIFT = 3,
	localparam int CW = $clog2(MAX_IN_SIDE),
	localparam int OW = $clog2(MAX_OUT_SIDE),
	localparam int KW = $clog2(MAX_SCALE_SHIFT + 2)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic [nii_pkg::PIX_W-1:0]         pixel,
	input  logic                              start_of_frame,
	input  logic [nii_pkg::SIDE_CFG_W-1:0]    in_width,
	input  logic [nii_pkg::SIDE_CFG_W-1:0]    in_height,
	input  logic [nii_pkg::SHIFT_CFG_W-1:0]   scale_shift,
	output logic [KW-1:0]                     k,
	output logic [nii_pkg::PIX_W-1:0]         pixel_s1,
	output logic [OW-1:0]                     bc_s1,
	output logic [OW-1:0]                     br_s1,
	output nii_pkg::blk_ctl_t                 ctl_s1
);
	import nii_pkg::*;

	localparam int SW = $clog2(MAX_IN_SIDE + 1);
	localparam int RW = $clog2(MAX_OUT_SIDE + 1);

	logic [SW-1:0] w, h, c1, r1;
	logic [RW-1:0] rw, rh;
	logic [CW-1:0] msk, c0, r0, bcf, brf, col_n, row_n;
	logic [CW-1:0] col_q, row_q;
	logic          inblk, first, last, lof;

	always_comb begin
		w = SW'(in_width);
		if (in_width == '0) begin
			w = SW'(1);
		end else if (32'(in_width) > MAX_IN_SIDE) begin
			w = SW'(MAX_IN_SIDE);
		end
		h = SW'(in_height);
		if (in_height == '0) begin
			h = SW'(1);
		end else if (32'(in_height) > MAX_IN_SIDE) begin
			h = SW'(MAX_IN_SIDE);
		end

		if (32'(scale_shift) > MAX_SCALE_SHIFT) begin
			k = KW'(MAX_SCALE_SHIFT);
		end else begin
			k = KW'(scale_shift);
		end

		if (32'(w >> k) > MAX_OUT_SIDE) begin
			rw = RW'(MAX_OUT_SIDE);
		end else begin
			rw = RW'(w >> k);
		end
		if (32'(h >> k) > MAX_OUT_SIDE) begin
			rh = RW'(MAX_OUT_SIDE);
		end else begin
			rh = RW'(h >> k);
		end

		msk = CW'((32'd1 << k) - 32'd1);

		c0 = start_of_frame ? '0 : col_q;
		r0 = start_of_frame ? '0 : row_q;
		if (SW'(c0) >= w) begin
			c0 = '0;
		end
		if (SW'(r0) >= h) begin
			r0 = '0;
		end

		bcf   = c0 >> k;
		brf   = r0 >> k;
		inblk = (32'(bcf) < 32'(rw)) && (32'(brf) < 32'(rh));
		first = ((c0 & msk) == '0) && ((r0 & msk) == '0);
		last  = ((c0 & msk) == msk) && ((r0 & msk) == msk);
		lof   = (32'(brf) + 32'd1 == 32'(rh)) && (32'(bcf) + 32'd1 == 32'(rw));

		c1 = SW'(c0) + SW'(1);
		r1 = SW'(r0) + SW'(1);
		if (c1 >= w) begin
			col_n = '0;
			row_n = (r1 >= h) ? '0 : CW'(r1);
		end else begin
			col_n = CW'(c1);
			row_n = r0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= '{vld: in_valid, inblk: inblk, first: first, last: last, lof: lof};
			if (in_valid) begin
				col_q <= col_n;
				row_q <= row_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pixel_s1 <= pixel;
			bc_s1    <= OW'(bcf);
			br_s1    <= OW'(brf);
		end
	end

endmodule

`default_nettype wire

// File: rtl/nii_accum.sv
`default_nettype none

module nii_accum #(
	parameter int MAX_OUT_SIDE = 1024,
	parameter int MAX_SCALE_SHIFT = 3,
	localparam int OW = $clog2(MAX_OUT_SIDE),
	localparam int AW = nii_pkg::PIX_W + 2 * MAX_SCALE_SHIFT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic [nii_pkg::PIX_W-1:0] pixel_s1,
	input  logic [OW-1:0]             bc_s1,
	input  logic [OW-1:0]             br_s1,
	input  nii_pkg::blk_ctl_t         ctl_s1,
	output logic [AW-1:0]             acc_s3,
	output logic [OW-1:0]             bc_s3,
	output logic [OW-1:0]             br_s3,
	output nii_pkg::blk_ctl_t         ctl_s3
);
	import nii_pkg::*;

	logic [AW-1:0]    acc_mem [MAX_OUT_SIDE];
	logic [AW-1:0]    acc_rd_s2, acc_base, acc_sum;
	logic [PIX_W-1:0] pixel_s2;
	logic [OW-1:0]    bc_s2, br_s2;
	blk_ctl_t         ctl_s2;
	logic             hw_vld_q;
	logic [OW-1:0]    hw_bc_q;
	logic [AW-1:0]    hw_data_q;

	// last cycle's write is not yet seen by the registered read
	always_comb begin
		acc_base = (hw_vld_q && hw_bc_q == bc_s2) ? hw_data_q : acc_rd_s2;
		acc_sum  = ctl_s2.first ? AW'(pixel_s2) : acc_base + AW'(pixel_s2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_rd_s2 <= acc_mem[bc_s1];
			if (ctl_s2.vld && ctl_s2.inblk) begin
				acc_mem[bc_s2] <= acc_sum;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2   <= '0;
			ctl_s3   <= '0;
			hw_vld_q <= 1'b0;
		end else if (en) begin
			ctl_s2   <= ctl_s1;
			ctl_s3   <= '{vld: ctl_s2.vld && ctl_s2.inblk && ctl_s2.last,
				inblk: ctl_s2.inblk, first: ctl_s2.first, last: ctl_s2.last,
				lof: ctl_s2.lof};
			hw_vld_q <= ctl_s2.vld && ctl_s2.inblk;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pixel_s2  <= pixel_s1;
			bc_s2     <= bc_s1;
			br_s2     <= br_s1;
			hw_bc_q   <= bc_s2;
			hw_data_q <= acc_sum;
			acc_s3    <= acc_sum;
			bc_s3     <= bc_s2;
			br_s3     <= br_s2;
		end
	end

endmodule

`default_nettype wire

// File: rtl/nii_normalize.sv
`default_nettype none

module nii_normalize #(
	parameter int MAX_OUT_SIDE = 1024,
	parameter int MAX_SCALE_SHIFT = 3,
	localparam int OW = $clog2(MAX_OUT_SIDE),
	localparam int AW = nii_pkg::PIX_W + 2 * MAX_SCALE_SHIFT,
	localparam int KW = $clog2(MAX_SCALE_SHIFT + 2)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic [KW-1:0]                     k,
	input  logic [nii_pkg::MEAN_W-1:0]        mean_q8,
	input  logic [nii_pkg::INV_W-1:0]         inv_std_q16,
	input  logic [AW-1:0]                     acc_s3,
	input  logic [OW-1:0]                     bc_s3,
	input  logic [OW-1:0]                     br_s3,
	input  nii_pkg::blk_ctl_t                 ctl_s3,
	output logic signed [nii_pkg::NORM_W-1:0] v_s5,
	output logic [OW-1:0]                     bc_s5,
	output logic [OW-1:0]                     br_s5,
	output nii_pkg::blk_ctl_t                 ctl_s5
);
	import nii_pkg::*;

	localparam int EW = AW + PIX_W;
	localparam int QW = PROD_W - ROUND_SH;

	logic [EW-1:0]              avg_full;
	logic [AVG_W-1:0]           avg;
	logic signed [DIFF_W-1:0]   diff;
	logic signed [INV_W:0]      inv_s;
	logic signed [PROD_W-1:0]   prod_c, prod_s4, rnd;
	logic signed [QW-1:0]       q;
	logic                       pos_ovf, neg_ovf;
	logic [NORM_W-1:0]          sat;
	logic [OW-1:0]              bc_s4, br_s4;
	blk_ctl_t                   ctl_s4;

	// average in Q8.8: sum * 256 / 4^k
	always_comb begin
		avg_full = (EW'(acc_s3) << PIX_W) >> {k, 1'b0};
		avg      = AVG_W'(avg_full);
		diff     = $signed({1'b0, avg}) - $signed({1'b0, mean_q8});
		inv_s    = $signed({1'b0, inv_std_q16});
		prod_c   = diff * inv_s;
	end

	// round to nearest, ties up, then clamp to Q7.8
	always_comb begin
		rnd     = prod_s4 + ROUND_BIAS;
		q       = rnd[PROD_W-1:ROUND_SH];
		pos_ovf = !q[QW-1] && (|q[QW-2:NORM_W-1]);
		neg_ovf = q[QW-1] && !(&q[QW-2:NORM_W-1]);
		if (pos_ovf) begin
			sat = NORM_MAX;
		end else if (neg_ovf) begin
			sat = NORM_MIN;
		end else begin
			sat = q[NORM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else if (en) begin
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s4 <= prod_c;
			bc_s4   <= bc_s3;
			br_s4   <= br_s3;
			v_s5    <= $signed(sat);
			bc_s5   <= bc_s4;
			br_s5   <= br_s4;
		end
	end

endmodule

`default_nettype wire

// File: rtl/nii_integrate.sv
`default_nettype none

module nii_integrate #(
	parameter int MAX_OUT_SIDE = 1024,
	localparam int OW = $clog2(MAX_OUT_SIDE)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic signed [nii_pkg::NORM_W-1:0] v_s5,
	input  logic [OW-1:0]                     bc_s5,
	input  logic [OW-1:0]                     br_s5,
	input  nii_pkg::blk_ctl_t                 ctl_s5,
	output logic                              out_valid,
	output logic signed [nii_pkg::SUM_W-1:0]  area_sum,
	output logic [nii_pkg::POS_W-1:0]         out_row,
	output logic [nii_pkg::POS_W-1:0]         out_col,
	output logic                              last_of_frame
);
	import nii_pkg::*;

	logic [SUM_W-1:0] prev_mem [MAX_OUT_SIDE];
	logic [SUM_W-1:0] prev_rd_s6, rs_q, rs_new, rs_s6, above, integ, pw_data_q;
	logic [OW-1:0]    bc_s6, br_s6, pw_bc_q;
	blk_ctl_t         ctl_s6;
	logic             pw_vld_q;

	always_comb begin
		rs_new = ((bc_s5 == '0) ? '0 : rs_q)
			+ {{(SUM_W - NORM_W){v_s5[NORM_W-1]}}, v_s5};
		if (br_s6 == '0) begin
			above = '0;
		end else if (pw_vld_q && pw_bc_q == bc_s6) begin
			above = pw_data_q;
		end else begin
			above = prev_rd_s6;
		end
		integ = above + rs_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prev_rd_s6 <= prev_mem[bc_s5];
			if (ctl_s6.vld) begin
				prev_mem[bc_s6] <= integ;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rs_q      <= '0;
			ctl_s6    <= '0;
			pw_vld_q  <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			if (ctl_s5.vld) begin
				rs_q <= rs_new;
			end
			ctl_s6    <= ctl_s5;
			pw_vld_q  <= ctl_s6.vld;
			out_valid <= ctl_s6.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rs_s6         <= rs_new;
			bc_s6         <= bc_s5;
			br_s6         <= br_s5;
			pw_bc_q       <= bc_s6;
			pw_data_q     <= integ;
			area_sum      <= $signed(integ);
			out_row       <= POS_W'(br_s6);
			out_col       <= POS_W'(bc_s6);
			last_of_frame <= ctl_s6.lof;
		end
	end

endmodule

`default_nettype wire
